FILE: hdl/magic_crc16_frame_deframer_top_defines.svh
// Assertion macros used by the checker file of the frame deframer.
`ifndef MAGIC_CRC16_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define MAGIC_CRC16_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Property checked on the rising clock edge and ignored while reset is held.
`define MCFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame deframer check failed");

// Property checked on every rising clock edge, reset included.
`define MCFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frame deframer reset check failed");

`endif

FILE: hdl/mcfd_pkg.sv
// Shared types, constants and the CRC byte step of the frame deframer.
package mcfd_pkg;

  localparam logic [7:0]  MAGIC_FIRST  = 8'hA5;
  localparam logic [7:0]  MAGIC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [6:0]  RESULT_LIMIT = 7'd64;

  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_PROCESS = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OFF_HOLD = 3'd0,
    OFF_CLR  = 3'd1,
    OFF_INC  = 3'd2,
    OFF_SET2 = 3'd3,
    OFF_SET3 = 3'd4,
    OFF_SET4 = 3'd5,
    OFF_CRC  = 3'd6
  } off_op_t;

  typedef enum logic [2:0] {
    DROP_NONE     = 3'd0,
    DROP_AT       = 3'd1,
    DROP_ONE      = 3'd2,
    DROP_FRAME    = 3'd3,
    DROP_COLLAPSE = 3'd4
  } drop_op_t;

  typedef enum logic [1:0] {
    LOAD_NONE   = 2'd0,
    LOAD_STATUS = 2'd1,
    LOAD_BYTE   = 2'd2,
    LOAD_EMPTY  = 2'd3
  } load_op_t;

  typedef struct packed {
    logic     push;
    off_op_t  off_op;
    drop_op_t drop_op;
    load_op_t load_op;
    logic     prev_upd;
    logic     len_err;
    logic     crc_err;
    logic     good;
    logic     latch_plen;
    logic     crc_init;
    logic     crc_step;
    logic     latch_lo;
    logic     idx_clr;
    logic     idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_lt2;
    logic fill_lt6;
    logic is_5a;
    logic prev_a5;
    logic scan_last;
    logic plen_big;
    logic short_frame;
    logic crc_last;
    logic crc_ok;
    logic plen_zero;
    logic emit_last;
    logic out_ready;
  } dp_status_t;

  // One byte of CRC-16/CCITT-FALSE, most significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/mcfd_datapath.sv
// Datapath: byte ring buffer, scan offset, CRC, counters and result register.
module mcfd_datapath #(
  parameter int BUFFER_DEPTH = 512,
  parameter int PAYLOAD_MAX  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_rx_byte,
  input  mcfd_pkg::dp_cmd_t   cmd,
  output mcfd_pkg::dp_status_t status,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_command,
  output logic [6:0]          out_payload_length,
  output logic [7:0]          out_payload_byte,
  output logic [5:0]          out_byte_index,
  output logic                out_last,
  output logic [31:0]         out_crc_error_total,
  output logic [31:0]         out_length_error_total,
  output logic [31:0]         out_frame_total,
  output logic [7:0]          out_error_command,
  output logic                out_error_was_length
);
  import mcfd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = (FW > 9) ? FW : 9;
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(BUFFER_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
  localparam logic [7:0]    PLEN_MAX = 8'(PAYLOAD_MAX);

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
    return r[AW-1:0];
  endfunction

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [7:0]    rd_q_r;
  logic          prev_a5_r;
  logic [7:0]    cmd_r, plen_r, lo_r;
  logic [15:0]   crc_r;
  logic [6:0]    idx_r;
  logic [31:0]   crc_cnt_r, len_cnt_r, good_cnt_r;
  logic [7:0]    rec_cmd_r;
  logic          rec_len_r;
  logic          out_valid_r;

  logic [CW-1:0] fill_ext, plen_ext, drop_n;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [6:0]    emit_n;
  logic          is_a5, out_ready;

  assign fill_ext = CW'(fill_r);
  assign plen_ext = CW'(plen_r);
  assign rd_addr  = wrap({1'b0, CW'(head_r)} + {1'b0, off_r});
  assign wr_addr  = (fill_r == DEPTH_F) ? head_r : wrap({1'b0, CW'(head_r)} + {1'b0, fill_ext});
  assign is_a5    = rd_q_r == MAGIC_FIRST;
  assign emit_n   = (plen_r > 8'(RESULT_LIMIT)) ? RESULT_LIMIT : plen_r[6:0];
  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    status.fill_lt2    = fill_ext < CW'(2);
    status.fill_lt6    = fill_ext < CW'(6);
    status.is_5a       = rd_q_r == MAGIC_SECOND;
    status.prev_a5     = prev_a5_r;
    status.scan_last   = (off_r + CW'(1)) == fill_ext;
    status.plen_big    = rd_q_r > PLEN_MAX;
    status.short_frame = fill_ext < (CW'(rd_q_r) + CW'(6));
    status.crc_last    = off_r == (plen_ext + CW'(3));
    status.crc_ok      = {rd_q_r, lo_r} == crc_r;
    status.plen_zero   = plen_r == 8'd0;
    status.emit_last   = (idx_r + 7'd1) == emit_n;
    status.out_ready   = out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= in_rx_byte;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    case (cmd.off_op)
      OFF_CLR:  off_nxt = '0;
      OFF_INC:  off_nxt = off_r + CW'(1);
      OFF_SET2: off_nxt = CW'(2);
      OFF_SET3: off_nxt = CW'(3);
      OFF_SET4: off_nxt = CW'(4);
      OFF_CRC:  off_nxt = plen_ext + CW'(4);
      default:  off_nxt = off_r;
    endcase
  end

  always_comb begin
    case (cmd.drop_op)
      DROP_AT:    drop_n = off_r - CW'(1);
      DROP_ONE:   drop_n = CW'(1);
      DROP_FRAME: drop_n = plen_ext + CW'(6);
      default:    drop_n = '0;
    endcase
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.push) begin
      if (fill_r == DEPTH_F) begin
        head_nxt = wrap({1'b0, CW'(head_r)} + (CW + 1)'(1));
      end else begin
        fill_nxt = fill_r + FW'(1);
      end
    end else if (cmd.drop_op == DROP_COLLAPSE) begin
      // The last byte sits at the current offset; keep it only if it is A5.
      head_nxt = wrap({1'b0, CW'(head_r)} + {1'b0, off_r});
      fill_nxt = is_a5 ? FW'(1) : '0;
    end else if (cmd.drop_op != DROP_NONE) begin
      head_nxt = wrap({1'b0, CW'(head_r)} + {1'b0, drop_n});
      fill_nxt = fill_r - FW'(drop_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      off_r       <= '0;
      prev_a5_r   <= 1'b0;
      idx_r       <= '0;
      crc_cnt_r   <= '0;
      len_cnt_r   <= '0;
      good_cnt_r  <= '0;
      rec_cmd_r   <= '0;
      rec_len_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      off_r  <= off_nxt;
      if (cmd.off_op == OFF_CLR) begin
        prev_a5_r <= 1'b0;
      end else if (cmd.prev_upd) begin
        prev_a5_r <= is_a5;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 7'd1;
      end
      if (cmd.len_err) begin
        len_cnt_r <= len_cnt_r + 32'd1;
        rec_len_r <= 1'b1;
      end
      if (cmd.crc_err) begin
        crc_cnt_r <= crc_cnt_r + 32'd1;
        rec_cmd_r <= cmd_r;
        rec_len_r <= 1'b0;
      end
      if (cmd.good) begin
        good_cnt_r <= good_cnt_r + 32'd1;
      end
      if (cmd.load_op != LOAD_NONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_plen) begin
      plen_r <= rd_q_r;
    end
    if (cmd.crc_init) begin
      crc_r <= CRC_INIT;
    end else if (cmd.crc_step) begin
      crc_r <= crc_byte(crc_r, rd_q_r);
      if (off_r == CW'(2)) begin
        cmd_r <= rd_q_r;
      end
    end
    if (cmd.latch_lo) begin
      lo_r <= rd_q_r;
    end
    if (cmd.load_op != LOAD_NONE) begin
      out_crc_error_total    <= crc_cnt_r;
      out_length_error_total <= len_cnt_r;
      out_frame_total        <= good_cnt_r;
      out_error_command      <= rec_cmd_r;
      out_error_was_length   <= rec_len_r;
    end
    case (cmd.load_op)
      LOAD_STATUS: begin
        out_kind           <= KIND_STATUS;
        out_command        <= '0;
        out_payload_length <= '0;
        out_payload_byte   <= '0;
        out_byte_index     <= '0;
        out_last           <= 1'b1;
      end
      LOAD_BYTE: begin
        out_kind           <= KIND_BYTE;
        out_command        <= cmd_r;
        out_payload_length <= plen_r[6:0];
        out_payload_byte   <= rd_q_r;
        out_byte_index     <= idx_r[5:0];
        out_last           <= status.emit_last;
      end
      LOAD_EMPTY: begin
        out_kind           <= KIND_EMPTY;
        out_command        <= cmd_r;
        out_payload_length <= '0;
        out_payload_byte   <= '0;
        out_byte_index     <= '0;
        out_last           <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/mcfd_ctrl.sv
// Controller: state machine that sequences scan, length check, CRC and emission.
module mcfd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_stall,
  input  mcfd_pkg::dp_status_t status,
  output mcfd_pkg::dp_cmd_t    cmd
);
  import mcfd_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CHK   = 17'h00002,
    S_SRD   = 17'h00004,
    S_SCMP  = 17'h00008,
    S_LCHK  = 17'h00010,
    S_LRD   = 17'h00020,
    S_LCMP  = 17'h00040,
    S_CRD   = 17'h00080,
    S_CCMP  = 17'h00100,
    S_WRD1  = 17'h00200,
    S_WLO   = 17'h00400,
    S_WRD2  = 17'h00800,
    S_WHI   = 17'h01000,
    S_ERD   = 17'h02000,
    S_EOUT  = 17'h04000,
    S_EMPTY = 17'h08000,
    S_STAT  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (status.fill_lt2) begin
          state_nxt = S_STAT;
        end else begin
          cmd.off_op = OFF_CLR;
          state_nxt  = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (status.prev_a5 && status.is_5a) begin
          cmd.drop_op = DROP_AT;
          state_nxt   = S_LCHK;
        end else if (status.scan_last) begin
          cmd.drop_op = DROP_COLLAPSE;
          state_nxt   = S_STAT;
        end else begin
          cmd.prev_upd = 1'b1;
          cmd.off_op   = OFF_INC;
          state_nxt    = S_SRD;
        end
      end
      S_LCHK: begin
        if (status.fill_lt6) begin
          state_nxt = S_STAT;
        end else begin
          cmd.off_op = OFF_SET3;
          state_nxt  = S_LRD;
        end
      end
      S_LRD: state_nxt = S_LCMP;
      S_LCMP: begin
        if (status.plen_big) begin
          cmd.len_err = 1'b1;
          cmd.drop_op = DROP_ONE;
          state_nxt   = S_CHK;
        end else if (status.short_frame) begin
          state_nxt = S_STAT;
        end else begin
          cmd.latch_plen = 1'b1;
          cmd.crc_init   = 1'b1;
          cmd.off_op     = OFF_SET2;
          state_nxt      = S_CRD;
        end
      end
      S_CRD: state_nxt = S_CCMP;
      S_CCMP: begin
        cmd.crc_step = 1'b1;
        if (status.crc_last) begin
          cmd.off_op = OFF_CRC;
          state_nxt  = S_WRD1;
        end else begin
          cmd.off_op = OFF_INC;
          state_nxt  = S_CRD;
        end
      end
      S_WRD1: state_nxt = S_WLO;
      S_WLO: begin
        cmd.latch_lo = 1'b1;
        cmd.off_op   = OFF_INC;
        state_nxt    = S_WRD2;
      end
      S_WRD2: state_nxt = S_WHI;
      S_WHI: begin
        if (status.crc_ok) begin
          cmd.good    = 1'b1;
          cmd.off_op  = OFF_SET4;
          cmd.idx_clr = 1'b1;
          state_nxt   = status.plen_zero ? S_EMPTY : S_ERD;
        end else begin
          cmd.crc_err = 1'b1;
          cmd.drop_op = DROP_ONE;
          state_nxt   = S_CHK;
        end
      end
      S_ERD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (status.out_ready) begin
          cmd.load_op = LOAD_BYTE;
          if (status.emit_last) begin
            cmd.drop_op = DROP_FRAME;
            state_nxt   = S_IDLE;
          end else begin
            cmd.off_op  = OFF_INC;
            cmd.idx_inc = 1'b1;
            state_nxt   = S_ERD;
          end
        end
      end
      S_EMPTY: begin
        if (status.out_ready) begin
          cmd.load_op = LOAD_EMPTY;
          cmd.drop_op = DROP_FRAME;
          state_nxt   = S_IDLE;
        end
      end
      S_STAT: begin
        if (status.out_ready) begin
          cmd.load_op = LOAD_STATUS;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/magic_crc16_frame_deframer_top.sv
// Top level of the magic/length/CRC-16 frame deframer.
// A push item (mode 0) writes one received byte into a ring buffer of BUFFER_DEPTH
// bytes, dropping the oldest byte when the buffer is full. A process
// item (mode 1) searches the buffer for a frame of the form A5 5A, command, length,
// payload, CRC low, CRC high, where the CRC-16 (poly 1021, init FFFF) covers the
// command, length and payload bytes. Bad lengths and CRC mismatches are counted,
// one byte is dropped and the search starts over. A good frame is returned as one
// item per payload byte (at most 64), or as one empty-frame item, and is then
// removed; otherwise one status item is returned. Every result carries the error
// and frame counters as they stand after the item. The buffer has one read port
// with a registered output, so every byte that the process item visits is read in
// one state and used in the next, and each rejected frame restarts the scan. The
// input is stalled while an item is being processed; a finished result waits in an
// output register, so the next item can be accepted before it is taken.
module magic_crc16_frame_deframer_top #(
  parameter int BUFFER_DEPTH = 512,
  parameter int PAYLOAD_MAX  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_command,
  output logic [6:0]  out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  output logic [31:0] out_crc_error_total,
  output logic [31:0] out_length_error_total,
  output logic [31:0] out_frame_total,
  output logic [7:0]  out_error_command,
  output logic        out_error_was_length
);
  import mcfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller only sequences; all buffer, CRC and counter state is in the datapath.
  mcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mcfd_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PAYLOAD_MAX  (PAYLOAD_MAX)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_rx_byte             (in_rx_byte),
    .cmd                    (cmd),
    .status                 (status),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_kind               (out_kind),
    .out_command            (out_command),
    .out_payload_length     (out_payload_length),
    .out_payload_byte       (out_payload_byte),
    .out_byte_index         (out_byte_index),
    .out_last               (out_last),
    .out_crc_error_total    (out_crc_error_total),
    .out_length_error_total (out_length_error_total),
    .out_frame_total        (out_frame_total),
    .out_error_command      (out_error_command),
    .out_error_was_length   (out_error_was_length)
  );

endmodule

FILE: hdl/mcfd_checker.sv
// Port-level checker for the frame deframer and its bind to the top level.
`include "magic_crc16_frame_deframer_top_defines.svh"

module mcfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [6:0] out_payload_length,
  input logic       out_last
);
  import mcfd_pkg::*;

  `MCFD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `MCFD_ASSERT(a_status_last, clk, rst_n, out_valid && out_kind == KIND_STATUS |-> out_last)
  `MCFD_ASSERT(a_empty_frame, clk, rst_n, out_valid && out_kind == KIND_EMPTY |-> out_last && out_payload_length == 7'd0)
  `MCFD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind magic_crc16_frame_deframer_top mcfd_checker u_mcfd_checker (.*);
